// ===== design/ucal_pkg.sv =====
// ----------------------------------------------------------------------------
// ucal_pkg
// Shared constants, tables and types for the seconds-to-calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ucal_pkg;

  localparam int STAGES = 7;

  localparam int SECS_W  = 32;
  localparam int DAYS_W  = 16;
  localparam int REM_W   = 17;
  localparam int YIDX_W  = 8;
  localparam int YDAY_W  = 17;
  localparam int YLEFT_W = 9;
  localparam int NYEARS  = 1 << YIDX_W;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
  localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;
  localparam logic [2:0]  EPOCH_WDAY    = 3'd4;
  localparam logic [11:0] EPOCH_YEAR    = 12'd1970;

  // floor division by constants via reciprocal multiply, exact over the used range
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;  // (t >> 7) / 675
  localparam int          DAY_SHIFT  = 35;
  localparam logic [16:0] HOUR_RECIP = 17'd74566;     // rem / 3600
  localparam int          HOUR_SHIFT = 28;
  localparam logic [12:0] MIN_RECIP  = 13'd4370;      // rem / 60
  localparam int          MIN_SHIFT  = 18;
  localparam logic [16:0] WDAY_RECIP = 17'd74899;     // days / 7
  localparam int          WDAY_SHIFT = 19;

  typedef logic [11:0][4:0]         mlen_tbl_t;
  typedef logic [12:0][8:0]         mstart_tbl_t;
  typedef logic [NYEARS-1:0][YDAY_W-1:0] ystart_tbl_t;
  typedef logic [NYEARS-1:0]        yleap_tbl_t;

  localparam mlen_tbl_t MONTH_LEN = {5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31,
                                     5'd30, 5'd31, 5'd30, 5'd31, 5'd28, 5'd31};

  function automatic logic is_leap_year(input int unsigned y);
    return ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
  endfunction

  function automatic ystart_tbl_t build_ystart();
    ystart_tbl_t tbl;
    int unsigned acc;
    acc = 0;
    for (int n = 0; n < NYEARS; n++) begin
      tbl[n] = acc[YDAY_W-1:0];
      acc = acc + (is_leap_year(1970 + n) ? 366 : 365);
    end
    return tbl;
  endfunction

  function automatic yleap_tbl_t build_yleap();
    yleap_tbl_t tbl;
    for (int n = 0; n < NYEARS; n++) begin
      tbl[n] = is_leap_year(1970 + n);
    end
    return tbl;
  endfunction

  function automatic mstart_tbl_t build_mstart(input logic leap);
    mstart_tbl_t tbl;
    int unsigned acc;
    acc = 0;
    for (int m = 0; m < 13; m++) begin
      tbl[m] = acc[8:0];
      if (m < 12) begin
        acc = acc + MONTH_LEN[m] + ((m == 1 && leap) ? 1 : 0);
      end
    end
    return tbl;
  endfunction

  localparam ystart_tbl_t YSTART      = build_ystart();
  localparam yleap_tbl_t  YLEAP       = build_yleap();
  localparam mstart_tbl_t MSTART_NORM = build_mstart(1'b0);
  localparam mstart_tbl_t MSTART_LEAP = build_mstart(1'b1);

endpackage

`default_nettype wire

// ===== design/ucal_clock.sv =====
// ----------------------------------------------------------------------------
// ucal_clock
// Splits seconds into day count, time of day and weekday, one stage per step.
// ----------------------------------------------------------------------------
`default_nettype none

module ucal_clock (
  input  wire logic                              clk,
  input  wire logic [ucal_pkg::STAGES-1:0]       en,
  input  wire logic [ucal_pkg::SECS_W-1:0]       secs,
  output logic      [ucal_pkg::DAYS_W-1:0]       days,
  output logic      [5:0]                        second_of_minute,
  output logic      [5:0]                        minute_of_hour,
  output logic      [4:0]                        hour_of_day,
  output logic      [2:0]                        weekday
);
  import ucal_pkg::*;

  logic [SECS_W-1:0] t1_r;
  logic [50:0]       p1_r, p1_nxt;
  logic [DAYS_W-1:0] days2_r, days2_nxt;
  logic [REM_W-1:0]  rem2_r, rem2_nxt;
  logic [REM_W-1:0]  rem3_r;
  logic [DAYS_W-1:0] d4_3_r, d4_3_nxt;
  logic [33:0]       hp3_r, hp3_nxt;
  logic [31:0]       wp3_r, wp3_nxt;
  logic [4:0]        hour4_r, hour4_nxt;
  logic [11:0]       rem4_r, rem4_nxt;
  logic [2:0]        wday4_r, wday4_nxt;
  logic [23:0]       mp5_r, mp5_nxt;
  logic [11:0]       rem5_r;
  logic [4:0]        hour5_r;
  logic [2:0]        wday5_r;
  logic [5:0]        min6_r, min6_nxt;
  logic [5:0]        sec6_r, sec6_nxt;
  logic [4:0]        hour6_r;
  logic [2:0]        wday6_r;
  logic [5:0]        min7_r, sec7_r;
  logic [4:0]        hour7_r;
  logic [2:0]        wday7_r;
  logic [12:0]       wq4;

  assign p1_nxt    = 51'(secs[SECS_W-1:7]) * 51'(DAY_RECIP);
  assign days2_nxt = p1_r[DAY_SHIFT+DAYS_W-1:DAY_SHIFT];
  assign rem2_nxt  = REM_W'(t1_r - 32'(days2_nxt) * 32'(SECS_PER_DAY));
  assign d4_3_nxt  = days2_r + DAYS_W'(EPOCH_WDAY);
  assign hp3_nxt   = 34'(rem2_r) * 34'(HOUR_RECIP);
  assign wp3_nxt   = 32'(d4_3_nxt) * 32'(WDAY_RECIP);
  assign hour4_nxt = hp3_r[HOUR_SHIFT+4:HOUR_SHIFT];
  assign rem4_nxt  = 12'(rem3_r - 17'(hour4_nxt) * 17'(SECS_PER_HOUR));
  assign wq4       = wp3_r[WDAY_SHIFT+12:WDAY_SHIFT];
  assign wday4_nxt = 3'(d4_3_r - 16'(wq4) * 16'(DAYS_PER_WEEK));
  assign mp5_nxt   = 24'(rem4_r) * 24'(MIN_RECIP);
  assign min6_nxt  = mp5_r[MIN_SHIFT+5:MIN_SHIFT];
  assign sec6_nxt  = 6'(rem5_r - 12'(min6_nxt) * 12'(SECS_PER_MIN));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t1_r <= secs;
      p1_r <= p1_nxt;
    end
    if (en[1]) begin
      days2_r <= days2_nxt;
      rem2_r  <= rem2_nxt;
    end
    if (en[2]) begin
      rem3_r <= rem2_r;
      d4_3_r <= d4_3_nxt;
      hp3_r  <= hp3_nxt;
      wp3_r  <= wp3_nxt;
    end
    if (en[3]) begin
      hour4_r <= hour4_nxt;
      rem4_r  <= rem4_nxt;
      wday4_r <= wday4_nxt;
    end
    if (en[4]) begin
      mp5_r   <= mp5_nxt;
      rem5_r  <= rem4_r;
      hour5_r <= hour4_r;
      wday5_r <= wday4_r;
    end
    if (en[5]) begin
      min6_r  <= min6_nxt;
      sec6_r  <= sec6_nxt;
      hour6_r <= hour5_r;
      wday6_r <= wday5_r;
    end
    if (en[6]) begin
      min7_r  <= min6_r;
      sec7_r  <= sec6_r;
      hour7_r <= hour6_r;
      wday7_r <= wday6_r;
    end
  end

  assign days             = days2_r;
  assign second_of_minute = sec7_r;
  assign minute_of_hour   = min7_r;
  assign hour_of_day      = hour7_r;
  assign weekday          = wday7_r;

endmodule

`default_nettype wire

// ===== design/ucal_year.sv =====
// ----------------------------------------------------------------------------
// ucal_year
// Binary search of the year-start table, two index bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ucal_year (
  input  wire logic                              clk,
  input  wire logic [ucal_pkg::STAGES-1:0]       en,
  input  wire logic [ucal_pkg::DAYS_W-1:0]       days,
  output logic      [ucal_pkg::YIDX_W-1:0]       year_idx,
  output logic      [ucal_pkg::YLEFT_W-1:0]      year_left,
  output logic                                   year_leap
);
  import ucal_pkg::*;

  function automatic logic [YIDX_W-1:0] ystep(input logic [DAYS_W-1:0] d,
                                              input logic [YIDX_W-1:0] n,
                                              input int b);
    logic [YIDX_W-1:0] cand;
    cand = n | (YIDX_W'(1) << b);
    if (YSTART[cand] <= YDAY_W'(d)) begin
      return cand;
    end
    return n;
  endfunction

  logic [DAYS_W-1:0]  d3_r, d4_r, d5_r;
  logic [YIDX_W-1:0]  n3_r, n3_nxt, n4_r, n4_nxt, n5_r, n5_nxt, n6_r, n6_nxt;
  logic [YLEFT_W-1:0] left6_r, left6_nxt;
  logic               leap6_r;

  assign n3_nxt    = ystep(days, ystep(days, '0, 7), 6);
  assign n4_nxt    = ystep(d3_r, ystep(d3_r, n3_r, 5), 4);
  assign n5_nxt    = ystep(d4_r, ystep(d4_r, n4_r, 3), 2);
  assign n6_nxt    = ystep(d5_r, ystep(d5_r, n5_r, 1), 0);
  assign left6_nxt = YLEFT_W'(YDAY_W'(d5_r) - YSTART[n6_nxt]);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      d3_r <= days;
      n3_r <= n3_nxt;
    end
    if (en[3]) begin
      d4_r <= d3_r;
      n4_r <= n4_nxt;
    end
    if (en[4]) begin
      d5_r <= d4_r;
      n5_r <= n5_nxt;
    end
    if (en[5]) begin
      n6_r    <= n6_nxt;
      left6_r <= left6_nxt;
      leap6_r <= YLEAP[n6_nxt];
    end
  end

  assign year_idx  = n6_r;
  assign year_left = left6_r;
  assign year_leap = leap6_r;

endmodule

`default_nettype wire

// ===== design/ucal_month.sv =====
// ----------------------------------------------------------------------------
// ucal_month
// Month and day from the day of year, plus the full year, into output regs.
// ----------------------------------------------------------------------------
`default_nettype none

module ucal_month (
  input  wire logic                              clk,
  input  wire logic [ucal_pkg::STAGES-1:0]       en,
  input  wire logic [ucal_pkg::YIDX_W-1:0]       year_idx,
  input  wire logic [ucal_pkg::YLEFT_W-1:0]      year_left,
  input  wire logic                              year_leap,
  output logic      [4:0]                        day_of_month,
  output logic      [3:0]                        month_number,
  output logic      [11:0]                       full_year
);
  import ucal_pkg::*;

  mstart_tbl_t mst;
  logic [3:0]  cnt;
  logic [3:0]  mon_nxt;
  logic [4:0]  day_nxt;
  logic [4:0]  day7_r;
  logic [3:0]  mon7_r;
  logic [11:0] year7_r;

  always_comb begin
    mst = year_leap ? MSTART_LEAP : MSTART_NORM;
    cnt = '0;
    for (int m = 1; m < 12; m++) begin
      if (year_left >= mst[m]) begin
        cnt = cnt + 4'd1;
      end
    end
    mon_nxt = cnt + 4'd1;
    day_nxt = 5'(year_left - mst[cnt] + 9'd1);
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      day7_r  <= day_nxt;
      mon7_r  <= mon_nxt;
      year7_r <= EPOCH_YEAR + 12'(year_idx);
    end
  end

  assign day_of_month = day7_r;
  assign month_number = mon7_r;
  assign full_year    = year7_r;

endmodule

`default_nettype wire

// ===== design/unix_time_to_calendar_top.sv =====
// ----------------------------------------------------------------------------
// unix_time_to_calendar_top
// Converts unsigned epoch seconds into Gregorian date, time and weekday.
// ----------------------------------------------------------------------------
// Fully pipelined: one transfer in and one out per cycle through seven
// register stages while out_ready stays high. A result is valid once it
// reaches the last stage, and leaves with out_ready high. Depth is set by the
// reciprocal multiplies that split off days, hours, minutes and weekday, and
// by the binary search of the year-start table, two bits per stage. Each
// stage holds only when it is full and the next one is stalled, so bubbles
// are squeezed out and the input keeps taking transfers while a result waits
// at the output, until all seven stages are full.
`default_nettype none

module unix_time_to_calendar_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [ucal_pkg::SECS_W-1:0]   in_unix_seconds,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [5:0]                    out_second_of_minute,
  output logic      [5:0]                    out_minute_of_hour,
  output logic      [4:0]                    out_hour_of_day,
  output logic      [2:0]                    out_weekday,
  output logic      [4:0]                    out_day_of_month,
  output logic      [3:0]                    out_month_number,
  output logic      [11:0]                   out_full_year
);
  import ucal_pkg::*;

  logic [STAGES-1:0]  vld_r, vld_nxt;
  logic [STAGES-1:0]  en;
  logic [DAYS_W-1:0]  days;
  logic [YIDX_W-1:0]  year_idx;
  logic [YLEFT_W-1:0] year_left;
  logic               year_leap;

  always_comb begin
    en[STAGES-1] = !vld_r[STAGES-1] || out_ready;
    for (int k = STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  always_comb begin
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < STAGES; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[STAGES-1];

  ucal_clock u_clock (
    .clk              (clk),
    .en               (en),
    .secs             (in_unix_seconds),
    .days             (days),
    .second_of_minute (out_second_of_minute),
    .minute_of_hour   (out_minute_of_hour),
    .hour_of_day      (out_hour_of_day),
    .weekday          (out_weekday)
  );

  ucal_year u_year (
    .clk       (clk),
    .en        (en),
    .days      (days),
    .year_idx  (year_idx),
    .year_left (year_left),
    .year_leap (year_leap)
  );

  ucal_month u_month (
    .clk          (clk),
    .en           (en),
    .year_idx     (year_idx),
    .year_left    (year_left),
    .year_leap    (year_leap),
    .day_of_month (out_day_of_month),
    .month_number (out_month_number),
    .full_year    (out_full_year)
  );

endmodule

`default_nettype wire

// ===== tb/sv/calendar_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_checker
// Watches both channels of the epoch-to-calendar converter. Every accepted
// input is turned into the expected calendar date and time here. Each result
// transfer is then compared field by field with the oldest pending date.
// ----------------------------------------------------------------------------

module calendar_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_unix_seconds,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [5:0]  out_second_of_minute,
  input  logic [5:0]  out_minute_of_hour,
  input  logic [4:0]  out_hour_of_day,
  input  logic [2:0]  out_weekday,
  input  logic [4:0]  out_day_of_month,
  input  logic [3:0]  out_month_number,
  input  logic [11:0] out_full_year,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [2:0]  wday;
    logic [4:0]  mday;
    logic [3:0]  month;
    logic [11:0] year;
  } cal_date_t;

  cal_date_t   want_dates[$];
  int          fail_count = 0;
  int          n_taken    = 0;
  int          n_seen     = 0;
  int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  assign errors  = fail_count;
  assign pending = n_taken - n_seen;

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  function automatic cal_date_t to_calendar(input logic [31:0] stamp);
    cal_date_t   d;
    int unsigned days;
    int unsigned secs_left;
    int unsigned yr;
    int unsigned mon;
    int unsigned ylen;
    int unsigned mlen;
    bit          leap;
    days      = stamp / 86400;
    secs_left = stamp % 86400;
    d.hour    = 5'(secs_left / 3600);
    secs_left = secs_left % 3600;
    d.min     = 6'(secs_left / 60);
    d.sec     = 6'(secs_left % 60);
    d.wday    = 3'((days + 4) % 7);
    yr = 1970;
    forever begin
      ylen = leap_year(yr) ? 366 : 365;
      if (days < ylen) break;
      days -= ylen;
      yr++;
    end
    leap = leap_year(yr);
    mon  = 1;
    while (mon < 12) begin
      mlen = month_days[mon-1];
      if (mon == 2 && leap) mlen = 29;
      if (days < mlen) break;
      days -= mlen;
      mon++;
    end
    d.mday  = 5'(days + 1);
    d.month = 4'(mon);
    d.year  = 12'(yr);
    return d;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    cal_date_t w;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        n_seen <= n_seen + 1;
        if (want_dates.size() == 0) begin
          $error("result transfer with no conversion pending");
          fail_count++;
        end else begin
          w = want_dates.pop_front();
          check_field("second_of_minute", 32'(w.sec), 32'(out_second_of_minute));
          check_field("minute_of_hour", 32'(w.min), 32'(out_minute_of_hour));
          check_field("hour_of_day", 32'(w.hour), 32'(out_hour_of_day));
          check_field("weekday", 32'(w.wday), 32'(out_weekday));
          check_field("day_of_month", 32'(w.mday), 32'(out_day_of_month));
          check_field("month_number", 32'(w.month), 32'(out_month_number));
          check_field("full_year", 32'(w.year), 32'(out_full_year));
        end
      end
      if (in_valid && in_ready) begin
        want_dates.push_back(to_calendar(in_unix_seconds));
        n_taken <= n_taken + 1;
      end
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives epoch timestamps into the calendar converter with random gaps and
// output stalls. Directed dates around leap days, century years and the
// 32-bit limits come first, then random stamps biased toward midnights and
// the ends of the range. The checker beside the block judges every result.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int N_RANDOM   = 480;
  localparam int CYCLE_CAP  = 300000;
  localparam int DRAIN_WAIT = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_unix_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  out_second_of_minute;
  logic [5:0]  out_minute_of_hour;
  logic [4:0]  out_hour_of_day;
  logic [2:0]  out_weekday;
  logic [4:0]  out_day_of_month;
  logic [3:0]  out_month_number;
  logic [11:0] out_full_year;
  int          errors;
  int          pending;
  int          cycles = 0;
  int          stall_left = 0;
  int          rx_stretch = 0;
  bit          rx_calm = 1'b0;
  int          tx_stretch = 0;
  bit          tx_calm = 1'b0;

  logic [31:0] directed_stamps[] = '{
    32'd0,            32'hFFFF_FFFF,    32'hFFFF_FFFE,    32'h7FFF_FFFF,
    32'h8000_0000,    32'd86399,        32'd86400,        32'd31535999,
    32'd31536000,     32'd68169600,     32'd68255999,     32'd94608000,
    32'd946684799,    32'd946684800,    32'd951782400,    32'd951868800,
    32'd4102444799,   32'd4102444800,   32'd4107542399,   32'd4107542400,
    32'h5555_5555,    32'hAAAA_AAAA,    32'd3599,         32'd59
  };

  always #1 clk = ~clk;

  unix_time_to_calendar_top DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_unix_seconds      (in_unix_seconds),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_second_of_minute (out_second_of_minute),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_hour_of_day      (out_hour_of_day),
    .out_weekday          (out_weekday),
    .out_day_of_month     (out_day_of_month),
    .out_month_number     (out_month_number),
    .out_full_year        (out_full_year)
  );

  calendar_checker u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_unix_seconds      (in_unix_seconds),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_second_of_minute (out_second_of_minute),
    .out_minute_of_hour   (out_minute_of_hour),
    .out_hour_of_day      (out_hour_of_day),
    .out_weekday          (out_weekday),
    .out_day_of_month     (out_day_of_month),
    .out_month_number     (out_month_number),
    .out_full_year        (out_full_year),
    .errors               (errors),
    .pending              (pending)
  );

  function automatic int gap_cycles();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 11) return 0;
    if (pick < 18) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // result side: stretches of always-ready alternate with random stalls
  always @(posedge clk) begin
    if (rx_stretch == 0) begin
      rx_stretch <= $urandom_range(30, 200);
      rx_calm    <= ($urandom_range(0, 3) == 0);
    end else begin
      rx_stretch <= rx_stretch - 1;
    end
    if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rx_calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= gap_cycles();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic logic [31:0] random_stamp();
    longint unsigned day_idx;
    longint unsigned offset;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom();
      5, 6: begin
        day_idx = $urandom_range(0, 49709);
        offset  = $urandom_range(0, 1) ? $urandom_range(0, 3)
                                       : 86400 - $urandom_range(1, 4);
        return 32'(day_idx * 86400 + offset);
      end
      7, 8: return 32'hFFFF_FFFF - $urandom_range(0, 200000);
      default: return $urandom_range(0, 100000000);
    endcase
  endfunction

  task automatic send_stamp(input logic [31:0] stamp);
    int idle;
    in_valid        <= 1'b1;
    in_unix_seconds <= stamp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (tx_stretch == 0) begin
      tx_stretch = $urandom_range(20, 120);
      tx_calm    = ($urandom_range(0, 3) == 0);
    end else begin
      tx_stretch--;
    end
    idle = tx_calm ? 0 : gap_cycles();
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(posedge clk);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_stamps[i]) send_stamp(directed_stamps[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      send_stamp(random_stamp());
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== unix_time_to_calendar_top.f =====
design/ucal_pkg.sv
design/ucal_clock.sv
design/ucal_year.sv
design/ucal_month.sv
design/unix_time_to_calendar_top.sv
tb/sv/calendar_checker.sv
tb/sv/tb_top.sv
